/* design/bounded_work_stealing_deque_defines.svh */
// Assertion macros shared by the work-stealing deque modules.
`ifndef BOUNDED_WORK_STEALING_DEQUE_DEFINES_SVH
`define BOUNDED_WORK_STEALING_DEQUE_DEFINES_SVH

// Checks a condition at every clock edge outside reset.
`define BWSD_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Checks that a condition holds in the cycle after a trigger.
`define BWSD_ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

/* design/bwsd_pkg.sv */
// Package with the item types and request codes of the work-stealing deque.
`default_nettype none
package bwsd_pkg;

   localparam int TASK_W = 64;
   localparam int CNT_W  = 4;

   localparam logic [1:0] FUNC_PUSH  = 2'd0;
   localparam logic [1:0] FUNC_POP   = 2'd1;
   localparam logic [1:0] FUNC_STEAL = 2'd2;

   typedef struct packed {
      logic [1:0]        func;
      logic [TASK_W-1:0] task_word;
   } req_type;

   typedef struct packed {
      logic              ok;
      logic [TASK_W-1:0] task_out;
      logic [CNT_W-1:0]  entry_count;
      logic [CNT_W-1:0]  free_space;
   } rsp_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
      logic ok;
   } ctl_type;

endpackage
`default_nettype wire

/* design/bounded_work_stealing_deque.sv */
// Top level of the bounded work-stealing deque.
//
//   channel   ports                     handshake
//   request   start, busy, req_data     taken when start is high and busy is low
//   result    rsp_strobe, rsp_data      one cycle per result, cannot be held off
//
// A request can be accepted in every cycle outside reset; its result appears in the next cycle,
// when the registered read of the task RAM returns.
// Outside reset the sustained rate is one item per cycle, set by the single RAM port pair.
// Busy is high only while reset is asserted; reset clears the indices and count.
// The store needs no clearing pass, since only written entries are read.
`default_nettype none
`include "bounded_work_stealing_deque_defines.svh"
module bounded_work_stealing_deque #(
   parameter int DEPTH      = 16,
   parameter int TASK_WIDTH = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire bwsd_pkg::req_type req_data,
   output logic                   rsp_strobe,
   output bwsd_pkg::rsp_type      rsp_data
);
   import bwsd_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = (AW > CNT_W) ? AW : CNT_W;
   localparam logic [AW-1:0] FULL_COUNT = AW'(DEPTH - 1);

   logic                  fire;
   ctl_type               ctl;
   logic [AW-1:0]         wr_addr;
   logic [AW-1:0]         rd_addr;
   logic [AW-1:0]         count_next;
   logic [TASK_WIDTH-1:0] rd_data;
   logic [CW-1:0]         count_ext;
   logic [CW-1:0]         free_ext;

   logic                  valid_ff;
   logic                  ok_ff;
   logic                  take_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      free_ff;

   assign busy = reset;
   assign fire = start && !busy;

   bwsd_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .func       (req_data.func),
      .ctl        (ctl),
      .wr_addr    (wr_addr),
      .rd_addr    (rd_addr),
      .count_next (count_next)
   );

   bwsd_ram #(.WIDTH(TASK_WIDTH), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ctl.wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.task_word[TASK_WIDTH-1:0]),
      .rd_en   (ctl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign count_ext = CW'(count_next);
   assign free_ext  = CW'(FULL_COUNT - count_next);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= fire;
      end
      ok_ff    <= ctl.ok;
      take_ff  <= ctl.rd_en;
      count_ff <= count_ext[CNT_W-1:0];
      free_ff  <= free_ext[CNT_W-1:0];
   end

   assign rsp_strobe           = valid_ff;
   assign rsp_data.ok          = ok_ff;
   assign rsp_data.task_out    = take_ff ? TASK_W'(rd_data) : '0;
   assign rsp_data.entry_count = count_ff;
   assign rsp_data.free_space  = free_ff;

   // Every accepted item yields exactly one result in the following cycle.
   `BWSD_ASSERT_NEXT(a_strobe, fire, rsp_strobe, "accepted item gave no result")
   `BWSD_ASSERT_NEXT(a_no_strobe, !fire, !rsp_strobe, "result without accepted item")
   `BWSD_ASSERT_ALWAYS(a_fail_zero, !(rsp_strobe && !rsp_data.ok) || rsp_data.task_out == '0, "failed request returned data")

endmodule
`default_nettype wire

/* design/bwsd_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module bwsd_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* design/bwsd_ctrl.sv */
// Index and count control of the work-stealing deque.
`default_nettype none
`include "bounded_work_stealing_deque_defines.svh"
module bwsd_ctrl #(
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     fire,
   input  wire logic [1:0]               func,
   output bwsd_pkg::ctl_type             ctl,
   output logic      [$clog2(DEPTH)-1:0] wr_addr,
   output logic      [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [$clog2(DEPTH)-1:0] count_next
);
   import bwsd_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW-1:0] FULL_COUNT = AW'(DEPTH - 1);

   logic [AW-1:0] top_ff, top_in;
   logic [AW-1:0] bottom_ff, bottom_in;
   logic [AW-1:0] count_ff, count_in;

   always_comb begin
      top_in    = top_ff;
      bottom_in = bottom_ff;
      count_in  = count_ff;
      rd_addr   = top_ff;
      ctl       = '0;
      if (fire) begin
         case (func)
            FUNC_PUSH: begin
               if (count_ff != FULL_COUNT) begin
                  ctl.wr_en = 1'b1;
                  ctl.ok    = 1'b1;
                  bottom_in = bottom_ff + 1'b1;
                  count_in  = count_ff + 1'b1;
               end
            end
            FUNC_POP: begin
               if (count_ff != '0) begin
                  ctl.rd_en = 1'b1;
                  ctl.ok    = 1'b1;
                  bottom_in = bottom_ff - 1'b1;
                  rd_addr   = bottom_ff - 1'b1;
                  count_in  = count_ff - 1'b1;
               end
            end
            FUNC_STEAL: begin
               if (count_ff != '0) begin
                  ctl.rd_en = 1'b1;
                  ctl.ok    = 1'b1;
                  top_in    = top_ff + 1'b1;
                  count_in  = count_ff - 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign wr_addr    = bottom_ff;
   assign count_next = count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff    <= '0;
         bottom_ff <= '0;
         count_ff  <= '0;
      end else begin
         top_ff    <= top_in;
         bottom_ff <= bottom_in;
         count_ff  <= count_in;
      end
   end

   // The ring indices and the count must always describe the same span.
   `BWSD_ASSERT_ALWAYS(a_span, AW'(bottom_ff - top_ff) == count_ff, "index span differs from count")
   `BWSD_ASSERT_NEXT(a_push, ctl.wr_en, count_ff == $past(count_ff) + 1'b1, "push did not count up")
   `BWSD_ASSERT_NEXT(a_steal, ctl.rd_en && func == FUNC_STEAL, bottom_ff == $past(bottom_ff), "steal moved bottom")

endmodule
`default_nettype wire

/* verif/testbench.sv */
// Self-checking testbench for the bounded work-stealing deque: directed and random requests.
module testbench;
   import bwsd_pkg::*;

   localparam int RING_DEPTH = 16;
   localparam int MAX_HELD = RING_DEPTH - 1;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_ITEMS = 1625;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_strobe;
   rsp_type rsp_data;

   // Predicted contents and indices of the deque.
   logic [TASK_W-1:0] shadow_slots [RING_DEPTH];
   logic [CNT_W-1:0] shadow_top;
   logic [CNT_W-1:0] shadow_bottom;
   int shadow_count;

   rsp_type awaited_results [$];
   rsp_type want;
   int mismatches = 0;
   int results_checked = 0;
   int idle_cycles = 0;
   int pushes_stored = 0;
   int pops_taken = 0;
   int steals_taken = 0;
   int refused_full = 0;
   int refused_empty = 0;
   int unused_kind = 0;

   bounded_work_stealing_deque #(
      .DEPTH(RING_DEPTH),
      .TASK_WIDTH(TASK_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Applies one request to the predicted deque and returns the result it should give.
   function automatic rsp_type deque_apply(input req_type item);
      rsp_type result;
      result = '0;
      case (item.func)
         FUNC_PUSH: begin
            if (shadow_count < MAX_HELD) begin
               shadow_slots[shadow_bottom] = item.task_word;
               shadow_bottom = shadow_bottom + 1'b1;
               shadow_count++;
               pushes_stored++;
               result.ok = 1'b1;
            end else begin
               refused_full++;
            end
         end
         FUNC_POP: begin
            if (shadow_count > 0) begin
               shadow_bottom = shadow_bottom - 1'b1;
               result.task_out = shadow_slots[shadow_bottom];
               shadow_count--;
               pops_taken++;
               result.ok = 1'b1;
            end else begin
               refused_empty++;
            end
         end
         FUNC_STEAL: begin
            if (shadow_count > 0) begin
               result.task_out = shadow_slots[shadow_top];
               shadow_top = shadow_top + 1'b1;
               shadow_count--;
               steals_taken++;
               result.ok = 1'b1;
            end else begin
               refused_empty++;
            end
         end
         default: begin
            unused_kind++;
         end
      endcase
      result.entry_count = CNT_W'(shadow_count);
      result.free_space = CNT_W'(MAX_HELD - shadow_count);
      return result;
   endfunction

   task automatic report_mismatch(input string what, input logic [TASK_W-1:0] got,
                                  input logic [TASK_W-1:0] expected_value);
      mismatches++;
      $display("mismatch in %s at result %0d: got %h, expected %h", what,
               results_checked, got, expected_value);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         shadow_top = '0;
         shadow_bottom = '0;
         shadow_count = 0;
         idle_cycles = 0;
      end else begin
         if (start && !busy) begin
            awaited_results.push_back(deque_apply(req_data));
         end
         if (rsp_strobe) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("result with no request waiting", rsp_data.task_out, '0);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_data.ok !== want.ok)
                  report_mismatch("ok", rsp_data.ok, want.ok);
               if (rsp_data.task_out !== want.task_out)
                  report_mismatch("task_out", rsp_data.task_out, want.task_out);
               if (rsp_data.entry_count !== want.entry_count)
                  report_mismatch("entry_count", rsp_data.entry_count, want.entry_count);
               if (rsp_data.free_space !== want.free_space)
                  report_mismatch("free_space", rsp_data.free_space, want.free_space);
            end
            results_checked++;
         end
         if ((start && !busy) || rsp_strobe) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   task automatic send_request(input logic [1:0] func, input logic [TASK_W-1:0] word);
      req_type item;
      item.func = func;
      item.task_word = word;
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
   endtask

   task automatic pause_requests(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   function automatic logic [TASK_W-1:0] random_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   task automatic test_empty_requests();
      send_request(FUNC_POP, '1);
      send_request(FUNC_STEAL, '1);
      send_request(FUNC_UNUSED, '0);
   endtask

   // Fills the ring to capacity, extreme words first; then one more push, one unused kind.
   task automatic test_full_queue();
      send_request(FUNC_PUSH, '1);
      send_request(FUNC_PUSH, '0);
      send_request(FUNC_PUSH, {16{4'hA}});
      send_request(FUNC_PUSH, {16{4'h5}});
      send_request(FUNC_PUSH, {1'b1, {(TASK_W-1){1'b0}}});
      send_request(FUNC_PUSH, 64'd1);
      for (int i = 0; i < MAX_HELD - 6; i++) begin
         send_request(FUNC_PUSH, {$urandom(), $urandom()});
      end
      send_request(FUNC_PUSH, {16{4'hC}});
      send_request(FUNC_UNUSED, '1);
   endtask

   task automatic test_pop_and_steal_order();
      send_request(FUNC_POP, '0);
      send_request(FUNC_STEAL, '0);
      send_request(FUNC_PUSH, '0);
      send_request(FUNC_POP, '1);
   endtask

   // Phases may lean toward filling or draining so that full and empty are reached often.
   task automatic test_random_traffic(input int item_total);
      int sent;
      int phase_left;
      int push_pct;
      int burst_left;
      int roll;
      bit steady;
      logic [1:0] func;
      sent = 0;
      phase_left = 0;
      burst_left = 0;
      push_pct = 50;
      steady = 1'b0;
      while (sent < item_total) begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(10, 60);
            case ($urandom_range(0, 3))
               0: push_pct = 85;
               1: push_pct = 15;
               2: push_pct = 50;
               default: push_pct = $urandom_range(10, 90);
            endcase
            steady = ($urandom_range(0, 3) == 0);
         end
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!steady && $urandom_range(0, 2) != 0) begin
               pause_requests($urandom_range(1, 8));
            end
         end
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            func = FUNC_UNUSED;
         end else if (roll < 3 + push_pct * 97 / 100) begin
            func = FUNC_PUSH;
         end else if ($urandom_range(0, 1) == 0) begin
            func = FUNC_POP;
         end else begin
            func = FUNC_STEAL;
         end
         send_request(func, random_word());
         sent++;
         phase_left--;
         burst_left--;
      end
   endtask

   task automatic finish_run();
      start <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("checked %0d results: %0d pushes stored, %0d pops, %0d steals",
               results_checked, pushes_stored, pops_taken, steals_taken);
      $display("refusals: %0d on a full ring, %0d on an empty one; %0d unused request kinds",
               refused_full, refused_empty, unused_kind);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_empty_requests();
      test_full_queue();
      test_pop_and_steal_order();
      test_random_traffic(RANDOM_ITEMS);
      finish_run();
   end

endmodule

/* files.f */
+incdir+design
design/bwsd_pkg.sv
design/bwsd_ram.sv
design/bwsd_ctrl.sv
design/bounded_work_stealing_deque.sv
verif/testbench.sv
